// ===== hdl/keyed_binary_semaphore_table_assert.svh =====
// Assertion macros for the semaphore table.
// Each one expects signals named clock and reset in the using scope.
`ifndef KEYED_BINARY_SEMAPHORE_TABLE_ASSERT_SVH
`define KEYED_BINARY_SEMAPHORE_TABLE_ASSERT_SVH

// same-cycle implication
`define KBST_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KBST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/kbst_pkg.sv =====
package kbst_pkg;

   localparam int KeyWidth    = 32;
   localparam int OpWidth     = 3;
   localparam int IndexWidth  = 7;
   localparam int StatusWidth = 3;

   // operation codes
   localparam logic [OpWidth-1:0] OP_CREATE  = 3'd0;
   localparam logic [OpWidth-1:0] OP_GET     = 3'd1;
   localparam logic [OpWidth-1:0] OP_DESTROY = 3'd2;
   localparam logic [OpWidth-1:0] OP_TAKE    = 3'd3;
   localparam logic [OpWidth-1:0] OP_GIVE    = 3'd4;

   // status codes
   localparam logic [StatusWidth-1:0] STAT_OK        = 3'd0;
   localparam logic [StatusWidth-1:0] STAT_BAD_KEY   = 3'd1;
   localparam logic [StatusWidth-1:0] STAT_NONE      = 3'd2;
   localparam logic [StatusWidth-1:0] STAT_MISMATCH  = 3'd3;
   localparam logic [StatusWidth-1:0] STAT_BAD_INDEX = 3'd4;
   localparam logic [StatusWidth-1:0] STAT_EMPTY     = 3'd5;

   typedef struct packed {
      logic                valid;
      logic [KeyWidth-1:0] key;
      logic                count;
      logic                order;
   } entry_type;

endpackage

// ===== hdl/kbst_req_if.sv =====
interface kbst_req_if;
   import kbst_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OpWidth-1:0]    operation;
   logic [KeyWidth-1:0]   sem_key;
   logic                  initial_full;
   logic                  queue_order;
   logic [IndexWidth-1:0] sem_index;

   modport source (output valid, operation, sem_key, initial_full, queue_order, sem_index,
                   input ready);
   modport sink   (input valid, operation, sem_key, initial_full, queue_order, sem_index,
                   output ready);
endinterface

// ===== hdl/kbst_rsp_if.sv =====
interface kbst_rsp_if;
   import kbst_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [StatusWidth-1:0] status;
   logic [IndexWidth-1:0]  result_index;
   logic                   give_when_full;

   modport source (output valid, status, result_index, give_when_full, input ready);
   modport sink   (input valid, status, result_index, give_when_full, output ready);
endinterface

// ===== hdl/keyed_binary_semaphore_table.sv =====
// Keyed binary semaphore table, one request at a time over a one-read one-write entry RAM.
// Create/get scan the table with one entry read per cycle and stop early on a key hit;
//   destroy/take/give pass through the fetch and index states; a zero key, an out-of-range
//   index or an unused code is answered without touching the table.
// A new request is taken only after the response to the last one has transferred.
// Reset: synchronous; a clearing pass then writes every entry, req ready low.
module keyed_binary_semaphore_table #(
   parameter int ENTRIES = 128
) (
   input  logic       clock,
   input  logic       reset,
   kbst_req_if.sink   req_chan,
   kbst_rsp_if.source rsp_chan
);
   import kbst_pkg::*;

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [AW-1:0] LastAddr = AW'(ENTRIES - 1);

   typedef enum logic [2:0] {
      S_CLEAR,   // post-reset sweep, writes an invalid entry per cycle
      S_IDLE,    // waiting for a request transfer
      S_FETCH,   // read the entry named by sem_index
      S_INDEX,   // act on the fetched entry
      S_SCAN,    // key search, one read issued and one entry checked per cycle
      S_RESP     // response held until the rsp transfer
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic [OpWidth-1:0]    op_ff, op_in;
   logic [KeyWidth-1:0]   key_ff, key_in;
   logic                  full_ff, full_in;
   logic                  order_ff, order_in;
   logic [IndexWidth-1:0] idx_ff, idx_in;

   // sequencer
   logic [AW-1:0] ptr_ff, ptr_in;            // clear / scan address
   logic          issue_done_ff, issue_done_in;
   logic          chk_live_ff, chk_live_in;  // rd_data_ff holds a scanned entry
   logic          free_found_ff, free_found_in;
   logic [AW-1:0] free_addr_ff, free_addr_in;

   // response
   logic [StatusWidth-1:0] status_ff, status_in;
   logic [IndexWidth-1:0]  rindex_ff, rindex_in;
   logic                   warn_ff, warn_in;

   // entry RAM, one read and one write port
   entry_type     mem [ENTRIES];
   entry_type     rd_data_ff;
   logic [AW-1:0] chk_addr_ff;
   logic [AW-1:0] mem_raddr;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   entry_type     mem_wdata;

   logic req_xfer, rsp_xfer;
   logic idx_in_range;
   logic hit, slot_free;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = (state_ff == S_RESP);
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.result_index   = rindex_ff;
   assign rsp_chan.give_when_full = warn_ff;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_xfer = rsp_chan.valid && rsp_chan.ready;

   // index range check; always true once the table is 128 or deeper
   assign idx_in_range = (32'(req_chan.sem_index) < 32'(ENTRIES));

   assign hit       = rd_data_ff.valid && (rd_data_ff.key == key_ff);
   assign slot_free = !rd_data_ff.valid;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      full_in       = full_ff;
      order_in      = order_ff;
      idx_in        = idx_ff;
      ptr_in        = ptr_ff;
      issue_done_in = issue_done_ff;
      chk_live_in   = 1'b0;
      free_found_in = free_found_ff;
      free_addr_in  = free_addr_ff;
      status_in     = status_ff;
      rindex_in     = rindex_ff;
      warn_in       = warn_ff;
      mem_raddr     = ptr_ff;
      mem_we        = 1'b0;
      mem_waddr     = ptr_ff;
      mem_wdata     = '0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = '0;
            if (ptr_ff == LastAddr) begin
               ptr_in   = '0;
               state_in = S_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (req_xfer) begin
               op_in         = req_chan.operation;
               key_in        = req_chan.sem_key;
               full_in       = req_chan.initial_full;
               order_in      = req_chan.queue_order;
               idx_in        = req_chan.sem_index;
               status_in     = STAT_OK;
               rindex_in     = '0;
               warn_in       = 1'b0;
               ptr_in        = '0;
               issue_done_in = 1'b0;
               free_found_in = 1'b0;
               case (req_chan.operation) inside
                  OP_CREATE, OP_GET: begin
                     if (req_chan.sem_key == '0) begin
                        status_in = STAT_BAD_KEY;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_DESTROY, OP_TAKE, OP_GIVE: begin
                     if (idx_in_range) begin
                        state_in = S_FETCH;
                     end else begin
                        status_in = STAT_BAD_INDEX;
                        state_in  = S_RESP;
                     end
                  end
                  default: state_in = S_RESP;  // unused codes: plain ok
               endcase
            end
         end

         S_FETCH: begin
            mem_raddr = AW'(idx_ff);
            state_in  = S_INDEX;
         end

         S_INDEX: begin
            mem_waddr = AW'(idx_ff);
            mem_wdata = rd_data_ff;
            if (!rd_data_ff.valid) begin
               status_in = STAT_BAD_INDEX;
            end else begin
               case (op_ff)
                  OP_DESTROY: begin
                     mem_we    = 1'b1;
                     mem_wdata = '0;
                  end
                  OP_TAKE: begin
                     if (!rd_data_ff.count) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        mem_we          = 1'b1;
                        mem_wdata.count = 1'b0;
                     end
                  end
                  OP_GIVE: begin
                     warn_in         = rd_data_ff.count;  // saturate, flag it
                     mem_we          = 1'b1;
                     mem_wdata.count = 1'b1;
                  end
                  default: ;
               endcase
            end
            state_in = S_RESP;
         end

         S_SCAN: begin
            // issue side
            if (!issue_done_ff) begin
               mem_raddr   = ptr_ff;
               chk_live_in = 1'b1;
               if (ptr_ff == LastAddr) begin
                  issue_done_in = 1'b1;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
            // check side, behind the read register; the lowest matching entry wins
            if (chk_live_ff) begin
               if (hit) begin
                  state_in = S_RESP;
                  if ((op_ff == OP_CREATE) && (rd_data_ff.order != order_ff)) begin
                     status_in = STAT_MISMATCH;
                  end else begin
                     rindex_in = IndexWidth'(chk_addr_ff);
                  end
               end else begin
                  if (slot_free && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_addr_in  = chk_addr_ff;
                  end
                  if (chk_addr_ff == LastAddr) begin
                     state_in = S_RESP;
                     if ((op_ff == OP_CREATE) && (free_found_ff || slot_free)) begin
                        // claim the lowest free entry
                        mem_we          = 1'b1;
                        mem_waddr       = free_found_ff ? free_addr_ff : chk_addr_ff;
                        mem_wdata.valid = 1'b1;
                        mem_wdata.key   = key_ff;
                        mem_wdata.count = full_ff;
                        mem_wdata.order = order_ff;
                        rindex_in       = IndexWidth'(mem_waddr);
                     end else begin
                        status_in = STAT_NONE;
                     end
                  end
               end
            end
         end

         S_RESP: begin
            if (rsp_xfer) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         ptr_ff        <= '0;
         issue_done_ff <= 1'b0;
         chk_live_ff   <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         issue_done_ff <= issue_done_in;
         chk_live_ff   <= chk_live_in;
         free_found_ff <= free_found_in;
      end
      op_ff        <= op_in;
      key_ff       <= key_in;
      full_ff      <= full_in;
      order_ff     <= order_in;
      idx_ff       <= idx_in;
      free_addr_ff <= free_addr_in;
      status_ff    <= status_in;
      rindex_ff    <= rindex_in;
      warn_ff      <= warn_in;
   end

   // entry RAM
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff  <= mem[mem_raddr];
      chk_addr_ff <= mem_raddr;
   end

   `include "keyed_binary_semaphore_table_assert.svh"

   // table only changes in the clearing pass or while a request is being worked
   `KBST_ASSERT_NOW(a_no_write_idle, (state_ff == S_IDLE) || (state_ff == S_RESP), !mem_we, "table written outside a request")

   // warning only comes with an ok status
   `KBST_ASSERT_NOW(a_warn_ok, rsp_chan.valid && rsp_chan.give_when_full, (rsp_chan.status == STAT_OK) && (op_ff == OP_GIVE), "give_when_full on a non-give or failed response")

   // any failure returns index zero
   `KBST_ASSERT_NOW(a_err_index, rsp_chan.valid && (rsp_chan.status != STAT_OK), rsp_chan.result_index == '0, "nonzero index with error status")

   // after a response transfer the block takes the next request at once
   `KBST_ASSERT_NEXT(a_resp_to_idle, rsp_xfer, req_chan.ready, "not ready after response transfer")

endmodule

// ===== verif/keyed_binary_semaphore_table_tb.sv =====
module keyed_binary_semaphore_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kbst_pkg::*;

   localparam int Entries     = 128;
   localparam int KeyPoolSize = 170;
   // create/get may scan the whole table, pad generously
   localparam int DrainCycles = 200;
   // receiver back-pressure plan, in cycles since reset release
   localparam int HoldStart   = 20000;
   localparam int HoldLen     = 600;
   localparam int CalmRxFirst = 40000;
   localparam int CalmRxLast  = 60000;
   // sender runs without gaps for this span of transfers
   localparam int CalmTxFirst = 500;
   localparam int CalmTxLast  = 650;
   localparam int MaxLogged   = 100;

   // codes 5..7 are not operations; the block must answer ok and touch nothing
   localparam logic [OpWidth-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OpWidth-1:0] OP_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [OpWidth-1:0]    operation;
      logic [KeyWidth-1:0]   sem_key;
      logic                  initial_full;
      logic                  queue_order;
      logic [IndexWidth-1:0] sem_index;
   } sem_req_type;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [IndexWidth-1:0]  result_index;
      logic                   give_when_full;
   } sem_rsp_type;

   logic clock;
   logic reset;

   kbst_req_if req_if ();
   kbst_rsp_if rsp_if ();

   keyed_binary_semaphore_table #(
      .ENTRIES (Entries)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // ---------------------------------------------------------------------
   // Semaphore table shadow, updated once per accepted request transfer
   // ---------------------------------------------------------------------
   logic                tbl_valid [Entries];
   logic [KeyWidth-1:0] tbl_key   [Entries];
   logic                tbl_count [Entries];
   logic                tbl_order [Entries];

   sem_req_type op_backlog_q [$];  // requests not yet offered
   sem_rsp_type awaited_rsp_q [$]; // responses owed by the block, oldest first
   sem_req_type offered;           // request currently on the req channel
   int unsigned sent_count;
   int unsigned err_count;
   int unsigned stall_cycle;

   logic [KeyWidth-1:0] key_pool [KeyPoolSize];

   task automatic log_error(input string msg);
      err_count++;
      if (err_count <= MaxLogged)
         $display("ERROR @%0t: %s", $time, msg);
   endtask

   // Applies one request to the shadow table and returns the answer it owes.
   function automatic sem_rsp_type semaphore_apply(input sem_req_type r);
      sem_rsp_type o;
      int          hit;
      int          i;
      o.status         = STAT_OK;
      o.result_index   = '0;
      o.give_when_full = 1'b0;
      hit              = -1;
      case (r.operation)
         OP_CREATE, OP_GET: begin
            if (r.sem_key == '0) begin
               o.status = STAT_BAD_KEY;
            end else begin
               // lowest valid entry holding the key wins
               for (i = 0; i < Entries; i++)
                  if (hit < 0 && tbl_valid[i] && tbl_key[i] == r.sem_key)
                     hit = i;
               if (hit >= 0) begin
                  if (r.operation == OP_CREATE && tbl_order[hit] != r.queue_order)
                     o.status = STAT_MISMATCH;
                  else
                     o.result_index = hit[IndexWidth-1:0];
               end else begin
                  // get misses; create claims the lowest free entry or reports full
                  o.status = STAT_NONE;
                  if (r.operation == OP_CREATE) begin
                     for (i = 0; i < Entries && o.status == STAT_NONE; i++) begin
                        if (!tbl_valid[i]) begin
                           tbl_valid[i]   = 1'b1;
                           tbl_key[i]     = r.sem_key;
                           tbl_count[i]   = r.initial_full;
                           tbl_order[i]   = r.queue_order;
                           o.result_index = IndexWidth'(i);
                           o.status       = STAT_OK;
                        end
                     end
                  end
               end
            end
         end
         OP_DESTROY, OP_TAKE, OP_GIVE: begin
            if (int'(r.sem_index) >= Entries || !tbl_valid[r.sem_index]) begin
               o.status = STAT_BAD_INDEX;
            end else if (r.operation == OP_DESTROY) begin
               tbl_valid[r.sem_index] = 1'b0;
               tbl_key[r.sem_index]   = '0;
               tbl_count[r.sem_index] = 1'b0;
               tbl_order[r.sem_index] = 1'b0;
            end else if (r.operation == OP_TAKE) begin
               // empty semaphore: status only, count stays 0
               if (!tbl_count[r.sem_index])
                  o.status = STAT_EMPTY;
               tbl_count[r.sem_index] = 1'b0;
            end else begin
               // give saturates at 1 and flags the overflow
               o.give_when_full       = tbl_count[r.sem_index];
               tbl_count[r.sem_index] = 1'b1;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic queue_op(input logic [OpWidth-1:0] op, input logic [KeyWidth-1:0] key,
                           input logic full, input logic order,
                           input logic [IndexWidth-1:0] idx);
      sem_req_type r;
      r.operation    = op;
      r.sem_key      = key;
      r.initial_full = full;
      r.queue_order  = order;
      r.sem_index    = idx;
      op_backlog_q.push_back(r);
   endtask

   // Mostly pool keys so lookups hit; a few fresh ones to probe misses.
   function automatic logic [KeyWidth-1:0] pick_key();
      logic [KeyWidth-1:0] k;
      if ($urandom_range(99) < 90) begin
         k = key_pool[$urandom_range(KeyPoolSize - 1)];
      end else begin
         k = $urandom;
         if (k == '0)
            k = 32'h0000_0002;
      end
      return k;
   endfunction

   task automatic queue_random_op();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 24)
         queue_op(OP_CREATE, pick_key(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  IndexWidth'($urandom_range(Entries - 1)));
      else if (roll < 42)
         queue_op(OP_GET, pick_key(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  IndexWidth'($urandom_range(Entries - 1)));
      else if (roll < 60)
         queue_op(OP_DESTROY, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  IndexWidth'($urandom_range(Entries - 1)));
      else if (roll < 75)
         queue_op(OP_TAKE, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  IndexWidth'($urandom_range(Entries - 1)));
      else if (roll < 91)
         queue_op(OP_GIVE, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  IndexWidth'($urandom_range(Entries - 1)));
      else if (roll < 95)
         queue_op(OpWidth'(OP_SPARE_LO + $urandom_range(OP_SPARE_HI - OP_SPARE_LO)),
                  $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  IndexWidth'($urandom_range(Entries - 1)));
      else
         // zero key on a lookup
         queue_op($urandom_range(1) ? OP_CREATE : OP_GET, '0, 1'($urandom_range(1)),
                  1'($urandom_range(1)), IndexWidth'($urandom_range(Entries - 1)));
   endtask

   // ---------------------------------------------------------------------
   // Clock, reset
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Request driver: pops the backlog, one transfer per valid&ready edge.
   // Prediction happens at the accepting edge, so the shadow table follows
   // the block's order of requests exactly.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : req_drive
      bit calm_tx;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            awaited_rsp_q.push_back(semaphore_apply(offered));
            sent_count++;
         end
         calm_tx = sent_count >= CalmTxFirst && sent_count < CalmTxLast;
         // slot is free after a transfer or while nothing is offered
         if (!req_if.valid || req_if.ready) begin
            if (op_backlog_q.size() > 0 && (calm_tx || $urandom_range(99) >= 19)) begin
               offered              = op_backlog_q.pop_front();
               req_if.valid        <= 1'b1;
               req_if.operation    <= offered.operation;
               req_if.sem_key      <= offered.sem_key;
               req_if.initial_full <= offered.initial_full;
               req_if.queue_order  <= offered.queue_order;
               req_if.sem_index    <= offered.sem_index;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response stall generator, with its own cycle count: random gaps, one
   // long hold-off that backs the block up into its request side, and a
   // window with ready held high.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_stall
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_cycle   = 0;
      end else begin
         stall_cycle++;
         if (stall_cycle >= HoldStart && stall_cycle < HoldStart + HoldLen)
            rsp_if.ready <= 1'b0;
         else if (stall_cycle >= CalmRxFirst && stall_cycle < CalmRxLast)
            rsp_if.ready <= 1'b1;
         else
            rsp_if.ready <= ($urandom_range(99) >= 19);
      end
   end

   // ---------------------------------------------------------------------
   // Response checker: each transfer against the oldest owed answer
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      sem_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_rsp_q.size() == 0) begin
            log_error("response transfer with nothing outstanding");
         end else begin
            want = awaited_rsp_q.pop_front();
            if (rsp_if.status !== want.status)
               log_error($sformatf("status got %0d want %0d",
                                   rsp_if.status, want.status));
            if (rsp_if.result_index !== want.result_index)
               log_error($sformatf("result_index got %0d want %0d",
                                   rsp_if.result_index, want.result_index));
            if (rsp_if.give_when_full !== want.give_when_full)
               log_error($sformatf("give_when_full got %0b want %0b",
                                   rsp_if.give_when_full, want.give_when_full));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of test
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int i;
      // known levels on every block input from time zero
      req_if.valid        = 1'b0;
      req_if.operation    = OP_CREATE;
      req_if.sem_key      = '0;
      req_if.initial_full = 1'b0;
      req_if.queue_order  = 1'b0;
      req_if.sem_index    = '0;
      rsp_if.ready        = 1'b0;
      sent_count          = 0;
      err_count           = 0;
      stall_cycle         = 0;
      for (i = 0; i < Entries; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_key[i]   = '0;
         tbl_count[i] = 1'b0;
         tbl_order[i] = 1'b0;
      end

      key_pool[0] = '1;
      key_pool[1] = 32'h0000_0001;
      for (i = 2; i < KeyPoolSize; i++) begin
         key_pool[i] = $urandom;
         if (key_pool[i] == '0)
            key_pool[i] = 32'h8000_0000;
      end

      // directed: empty table first, then each corner on a couple of entries
      queue_op(OP_CREATE,  '0,           1'b1, 1'b0, 7'd0);   // zero key
      queue_op(OP_GET,     '0,           1'b0, 1'b1, 7'd127); // zero key
      queue_op(OP_GET,     32'h1,        1'b0, 1'b0, 7'd0);   // not found
      queue_op(OP_TAKE,    32'h0,        1'b0, 1'b0, 7'd0);   // bad index
      queue_op(OP_GIVE,    32'h0,        1'b0, 1'b0, 7'd127); // bad index
      queue_op(OP_DESTROY, '1,           1'b1, 1'b1, 7'd5);   // bad index
      queue_op(OP_CREATE,  '1,           1'b1, 1'b0, 7'd0);   // claims entry 0, full
      queue_op(OP_CREATE,  32'h1,        1'b0, 1'b1, 7'd127); // claims entry 1, empty
      queue_op(OP_CREATE,  '1,           1'b0, 1'b0, 7'd0);   // existing key, same order
      queue_op(OP_CREATE,  '1,           1'b1, 1'b1, 7'd0);   // order flag mismatch
      queue_op(OP_GET,     32'h1,        1'b0, 1'b0, 7'd0);
      queue_op(OP_TAKE,    '0,           1'b0, 1'b0, 7'd0);   // full -> empty
      queue_op(OP_TAKE,    '0,           1'b0, 1'b0, 7'd0);   // take on empty
      queue_op(OP_GIVE,    '0,           1'b0, 1'b0, 7'd0);   // empty -> full
      queue_op(OP_GIVE,    '0,           1'b0, 1'b0, 7'd0);   // give on full
      queue_op(OP_TAKE,    '0,           1'b0, 1'b0, 7'd1);   // created empty
      queue_op(OP_DESTROY, '0,           1'b0, 1'b0, 7'd0);
      queue_op(OP_TAKE,    '0,           1'b0, 1'b0, 7'd0);   // destroyed entry
      queue_op(OP_GET,     '1,           1'b0, 1'b0, 7'd0);   // gone
      queue_op(OP_CREATE,  32'hA5A5_5A5A, 1'b1, 1'b1, 7'd0);  // reuses lowest free
      for (i = OP_SPARE_LO; i <= OP_SPARE_HI; i++)
         queue_op(i[OpWidth-1:0], $urandom, 1'b1, 1'b1, 7'd127);
      queue_op(OP_DESTROY, '0,           1'b0, 1'b0, 7'd1);
      queue_op(OP_DESTROY, '0,           1'b0, 1'b0, 7'd0);

      // fill past capacity: the last dozen creates see a full table
      for (i = 0; i < 140; i++)
         queue_op(OP_CREATE, key_pool[i], 1'($urandom_range(1)), 1'($urandom_range(1)),
                  IndexWidth'($urandom_range(Entries - 1)));
      // mixed traffic on a mostly full table
      for (i = 0; i < 600; i++)
         queue_random_op();
      // tear everything down, then a short tail on a near-empty table
      for (i = 0; i < Entries; i++)
         queue_op(OP_DESTROY, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  IndexWidth'(i));
      for (i = 0; i < 60; i++)
         queue_random_op();

      @(negedge clock);
      while (reset || op_backlog_q.size() > 0 || req_if.valid || awaited_rsp_q.size() > 0)
         @(negedge clock);
      // any stray late response lands in this window
      repeat (DrainCycles) @(negedge clock);
      if (awaited_rsp_q.size() > 0)
         log_error($sformatf("%0d responses never arrived", awaited_rsp_q.size()));

      if (err_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // hang guard, well above the slowest legal run
   initial begin : watchdog
      #4ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/kbst_pkg.sv
hdl/kbst_req_if.sv
hdl/kbst_rsp_if.sv
hdl/keyed_binary_semaphore_table.sv
verif/keyed_binary_semaphore_table_tb.sv
